/* design/tcpop_pkg.sv */
// package for the tcp option parser
// holds option kind codes, walker class codes and the result struct
// no dependencies
package tcpop_pkg;

  localparam int ByteW = 8;
  localparam int MssW = 16;
  localparam int ClassW = 3;
  localparam int PosW = 2;
  localparam int OutDataW = 32;

  // option kind codes
  localparam logic [ByteW-1:0] KIND_END = 8'd0;
  localparam logic [ByteW-1:0] KIND_NOP = 8'd1;
  localparam logic [ByteW-1:0] KIND_MSS = 8'd2;
  localparam logic [ByteW-1:0] KIND_WSCALE = 8'd3;
  localparam logic [ByteW-1:0] KIND_TSTAMP = 8'd8;

  // bytes left to skip after the timestamp kind byte
  localparam logic [ByteW-1:0] TSTAMP_SKIP = 8'd9;

  // walker class codes
  localparam logic [ClassW-1:0] CLS_KIND = 3'd0;
  localparam logic [ClassW-1:0] CLS_MSS = 3'd1;
  localparam logic [ClassW-1:0] CLS_WS = 3'd2;
  localparam logic [ClassW-1:0] CLS_SKIP = 3'd3;
  localparam logic [ClassW-1:0] CLS_LEN = 3'd4;

  // position of the next byte inside an mss or window scale option
  localparam logic [PosW-1:0] POS_NONE = 2'd0;
  localparam logic [PosW-1:0] POS_LEN = 2'd1;
  localparam logic [PosW-1:0] POS_VAL0 = 2'd2;
  localparam logic [PosW-1:0] POS_VAL1 = 2'd3;

  typedef struct packed {
    logic             stopped_early;
    logic [ByteW-1:0] wscale_value;
    logic             wscale_present;
    logic [MssW-1:0]  mss_value;
    logic             mss_present;
  } result_t;

endpackage

/* design/tcpop_walker.sv */
// option list walker: per-byte state update for the tcp option parser
// depends on tcpop_pkg
module tcpop_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [tcpop_pkg::ByteW-1:0]   opt_byte,
  input  logic                          last_byte,
  output tcpop_pkg::result_t            res
);

  logic [tcpop_pkg::ClassW-1:0] class_r, class_nxt;
  logic [tcpop_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [tcpop_pkg::ByteW-1:0]  skip_r, skip_nxt, skip_dec;
  logic [tcpop_pkg::ByteW-1:0]  mss_hi_r, mss_hi_nxt;
  logic [tcpop_pkg::MssW-1:0]   mss_r, mss_nxt;
  logic                         mss_seen_r, mss_seen_nxt;
  logic [tcpop_pkg::ByteW-1:0]  ws_r, ws_nxt;
  logic                         ws_seen_r, ws_seen_nxt;
  logic                         halted_r, halted_nxt;

  assign skip_dec = (skip_r != '0) ? skip_r - 8'd1 : skip_r;

  always_comb begin
    class_nxt    = class_r;
    pos_nxt      = pos_r;
    skip_nxt     = skip_r;
    mss_hi_nxt   = mss_hi_r;
    mss_nxt      = mss_r;
    mss_seen_nxt = mss_seen_r;
    ws_nxt       = ws_r;
    ws_seen_nxt  = ws_seen_r;
    halted_nxt   = halted_r;
    if (!halted_r) begin
      case (class_r)
        tcpop_pkg::CLS_KIND: begin
          if (opt_byte == tcpop_pkg::KIND_MSS) begin
            class_nxt = tcpop_pkg::CLS_MSS;
            pos_nxt   = tcpop_pkg::POS_LEN;
          end else if (opt_byte == tcpop_pkg::KIND_WSCALE) begin
            class_nxt = tcpop_pkg::CLS_WS;
            pos_nxt   = tcpop_pkg::POS_LEN;
          end else if (opt_byte == tcpop_pkg::KIND_TSTAMP) begin
            class_nxt = tcpop_pkg::CLS_SKIP;
            skip_nxt  = tcpop_pkg::TSTAMP_SKIP;
          end else if (opt_byte != tcpop_pkg::KIND_END &&
                       opt_byte != tcpop_pkg::KIND_NOP) begin
            class_nxt = tcpop_pkg::CLS_LEN;
          end
        end
        tcpop_pkg::CLS_MSS: begin
          if (pos_r == tcpop_pkg::POS_LEN) begin
            pos_nxt = tcpop_pkg::POS_VAL0;
          end else if (pos_r == tcpop_pkg::POS_VAL0) begin
            mss_hi_nxt = opt_byte;
            pos_nxt    = tcpop_pkg::POS_VAL1;
          end else begin
            mss_nxt      = {mss_hi_r, opt_byte};
            mss_seen_nxt = 1'b1;
            class_nxt    = tcpop_pkg::CLS_KIND;
            pos_nxt      = tcpop_pkg::POS_NONE;
          end
        end
        tcpop_pkg::CLS_WS: begin
          if (pos_r == tcpop_pkg::POS_LEN) begin
            pos_nxt = tcpop_pkg::POS_VAL0;
          end else begin
            ws_nxt      = opt_byte;
            ws_seen_nxt = 1'b1;
            class_nxt   = tcpop_pkg::CLS_KIND;
            pos_nxt     = tcpop_pkg::POS_NONE;
          end
        end
        tcpop_pkg::CLS_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            class_nxt = tcpop_pkg::CLS_KIND;
          end
        end
        tcpop_pkg::CLS_LEN: begin
          // zero length halts the walk, one or two ends at the length byte
          if (opt_byte == 8'd0) begin
            halted_nxt = 1'b1;
            class_nxt  = tcpop_pkg::CLS_KIND;
          end else if (opt_byte <= 8'd2) begin
            class_nxt = tcpop_pkg::CLS_KIND;
          end else begin
            skip_nxt  = opt_byte - 8'd2;
            class_nxt = tcpop_pkg::CLS_SKIP;
          end
        end
        default: begin
          class_nxt = tcpop_pkg::CLS_KIND;
        end
      endcase
    end
  end

  assign res.mss_present    = mss_seen_nxt;
  assign res.mss_value      = mss_seen_nxt ? mss_nxt : '0;
  assign res.wscale_present = ws_seen_nxt;
  assign res.wscale_value   = ws_seen_nxt ? ws_nxt : '0;
  assign res.stopped_early  = halted_nxt;

  // the last item of a run returns the walker to its reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      class_r    <= tcpop_pkg::CLS_KIND;
      pos_r      <= tcpop_pkg::POS_NONE;
      skip_r     <= '0;
      mss_hi_r   <= '0;
      mss_r      <= '0;
      mss_seen_r <= 1'b0;
      ws_r       <= '0;
      ws_seen_r  <= 1'b0;
      halted_r   <= 1'b0;
    end else if (step) begin
      class_r    <= class_nxt;
      pos_r      <= pos_nxt;
      skip_r     <= skip_nxt;
      mss_hi_r   <= mss_hi_nxt;
      mss_r      <= mss_nxt;
      mss_seen_r <= mss_seen_nxt;
      ws_r       <= ws_nxt;
      ws_seen_r  <= ws_seen_nxt;
      halted_r   <= halted_nxt;
    end
  end

  a_halt_class: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> class_r == tcpop_pkg::CLS_KIND)
    else $error("walker halted outside kind class");

  a_mss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (class_r == tcpop_pkg::CLS_MSS || class_r == tcpop_pkg::CLS_WS)
      |-> pos_r != tcpop_pkg::POS_NONE)
    else $error("option position lost inside mss or window scale");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    class_r == tcpop_pkg::CLS_SKIP |-> skip_r != '0)
    else $error("skip class with nothing left to skip");

endmodule

/* design/tcp_option_parser_unit.sv */
// top level of the tcp option parser: input register, walker, result register
// depends on tcpop_pkg and tcpop_walker

// Takes the options area of a SYN segment one byte per item (in_tlast on the
// final byte) and gives one result per options area, after its last byte has
// been walked: MSS and window scale values with presence flags, and a flag
// that an unknown option with zero length stopped the walk. Each byte is
// held in one input register and processed by the walker when it advances,
// so a new byte is taken every cycle unless the walker stalls; the only stall
// comes from a result that still waits in the output register when the next
// last byte needs it. A result is loaded into the output register when its
// last byte is walked and shows on out_tvalid until it is taken.
module tcp_option_parser_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // opt_byte
  input  logic                               in_tlast,  // last_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // mss_present, mss_value[16:1], wscale_present, wscale_value[25:18],
  // stopped_early, zero fill
  output logic [tcpop_pkg::OutDataW-1:0]     out_tdata
);

  logic                         in_valid_r;
  logic [tcpop_pkg::ByteW-1:0]  in_byte_r;
  logic                         in_last_r;
  logic                         advance;
  logic                         out_valid_r;
  tcpop_pkg::result_t           res;
  tcpop_pkg::result_t           res_r;

  // a non-last byte never waits on the output side
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  tcpop_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .opt_byte  (in_byte_r),
    .last_byte (in_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tcpop_pkg::OutDataW - $bits(tcpop_pkg::result_t)){1'b0}}, res_r};

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_load_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(advance && in_last_r))
    else $error("result appeared without a last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

endmodule
